FILE: rtl/fome_pkg.sv
package fome_pkg;

    // Widths of the order fields.
    localparam int SIZE_W  = 8;
    localparam int ID_W    = 32;
    localparam int TYPE_W  = 3;
    localparam int TAG_W   = 64;
    localparam int WORD_W  = 64;
    localparam int COUNT_W = 5;
    localparam int GROUP_W = 7;

    // Number of order-id groups above the lowest one.
    localparam int UPPER_GROUPS = 4;
    localparam int NGRP_W       = 3;

    // Message layout.
    localparam int MSG_BYTES  = 16;
    localparam int HEAD_BYTES = 4;
    localparam int TAIL_BYTES = MSG_BYTES - HEAD_BYTES;

    // Default depth of the queue between front and back.
    localparam int QUEUE_DEPTH_DEF = 2;

    // Fixed message bytes and marks.
    localparam logic [7:0] PMAP_BYTE     = 8'hFC;
    localparam logic [7:0] TEMPLATE_BYTE = 8'h81;
    localparam logic [7:0] EXP_BYTE      = 8'h80;
    localparam logic [7:0] PRICE_BYTE    = 8'h81;
    localparam logic [7:0] STOP_MARK     = 8'h80;
    localparam logic [7:0] SIZE_EXT_BYTE = 8'h01;

    // Byte counts reported on each word.
    localparam logic [COUNT_W-1:0] COUNT_FIRST = 5'd8;
    localparam logic [COUNT_W-1:0] COUNT_LAST  = 5'd16;

    // One classified order as it travels from front to back.
    typedef struct packed {
        logic [SIZE_W-1:0] order_size;
        logic [ID_W-1:0]   order_id;
        logic [TYPE_W-1:0] order_type;
        logic [TAG_W-1:0]  time_tag;
        logic              size_ext;
        logic [NGRP_W-1:0] upper_groups;
    } order_entry_t;

endpackage

FILE: rtl/fome_front.sv
module fome_front
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [fome_pkg::SIZE_W-1:0]     order_size,
    input  logic [fome_pkg::ID_W-1:0]       order_id,
    input  logic [fome_pkg::TYPE_W-1:0]     order_type,
    input  logic [fome_pkg::TAG_W-1:0]      time_tag,
    output logic                            entry_valid,
    output fome_pkg::order_entry_t          entry,
    input  logic                            entry_ready
);

    logic                   valid_reg;
    logic                   valid_next;
    fome_pkg::order_entry_t entry_reg;
    fome_pkg::order_entry_t entry_next;
    logic                   take;
    logic [fome_pkg::NGRP_W-1:0] ngrp;

    // The stage takes a beat when it is empty or its entry moves on this cycle.
    assign take = push && !full;
    assign full = valid_reg && !entry_ready;

    // Count the order-id groups above the lowest one, leading zero groups dropped.
    always_comb
    begin
        if (order_id[31:28] != '0)
        begin
            ngrp = 3'd4;
        end
        else if (order_id[27:21] != '0)
        begin
            ngrp = 3'd3;
        end
        else if (order_id[20:14] != '0)
        begin
            ngrp = 3'd2;
        end
        else if (order_id[13:7] != '0)
        begin
            ngrp = 3'd1;
        end
        else
        begin
            ngrp = 3'd0;
        end
    end

    // Next contents of the classification register.
    always_comb
    begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (valid_reg && entry_ready)
        begin
            valid_next = 1'b0;
        end
        if (take)
        begin
            valid_next              = 1'b1;
            entry_next.order_size   = order_size;
            entry_next.order_id     = order_id;
            entry_next.order_type   = order_type;
            entry_next.time_tag     = time_tag;
            entry_next.size_ext     = order_size[7];
            entry_next.upper_groups = ngrp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry_valid = valid_reg;
    assign entry       = entry_reg;

endmodule

FILE: rtl/fome_queue.sv
module fome_queue
#(
    parameter int DEPTH = fome_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_valid,
    output logic                   wr_ready,
    input  fome_pkg::order_entry_t wr_entry,
    output logic                   rd_valid,
    input  logic                   rd_pop,
    output fome_pkg::order_entry_t rd_entry
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    fome_pkg::order_entry_t store [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_wr;
    logic          do_rd;

    assign wr_ready = (count_reg != FULL_CNT);
    assign rd_valid = (count_reg != '0);
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_pop && rd_valid;
    assign rd_entry = store[rd_ptr_reg];

    // Pointer and fill-count update with explicit wrap.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            store[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

FILE: rtl/fome_back.sv
module fome_back
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             entry_valid,
    input  fome_pkg::order_entry_t           entry,
    output logic                             entry_pop,
    output logic                             empty,
    input  logic                             pop,
    output logic [fome_pkg::WORD_W-1:0]      data_word,
    output logic                             last_word,
    output logic [fome_pkg::COUNT_W-1:0]     byte_count,
    output logic [fome_pkg::TAG_W-1:0]       tag_out
);

    logic [fome_pkg::MSG_BYTES*8-1:0]  msg;
    logic [7:0]                        tail [fome_pkg::TAIL_BYTES];
    logic [7:0]                        grp  [fome_pkg::UPPER_GROUPS+1];
    logic [4:0]                        chunk_start;
    logic [4:0]                        ngrp_w;

    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic                              half_reg;
    logic                              half_next;
    logic [fome_pkg::WORD_W-1:0]       data_reg;
    logic                              last_reg;
    logic [fome_pkg::COUNT_W-1:0]      count_reg;
    logic [fome_pkg::TAG_W-1:0]        tag_reg;
    logic                              load;

    // Id groups, lowest first; the lowest carries the stop bit.
    always_comb
    begin
        grp[0] = fome_pkg::STOP_MARK | {1'b0, entry.order_id[6:0]};
        grp[1] = {1'b0, entry.order_id[13:7]};
        grp[2] = {1'b0, entry.order_id[20:14]};
        grp[3] = {1'b0, entry.order_id[27:21]};
        grp[4] = {4'b0, entry.order_id[31:28]};
    end

    assign chunk_start = entry.size_ext ? 5'd2 : 5'd1;
    assign ngrp_w      = {2'b0, entry.upper_groups};

    // Place each tail byte independently from the classified entry.
    always_comb
    begin
        for (int j = 0; j < fome_pkg::TAIL_BYTES; j++)
        begin
            logic [4:0] rel;
            logic [4:0] idx;
            rel = 5'(j) - chunk_start;
            idx = ngrp_w - rel;
            tail[j] = 8'h00;
            if (j == 0)
            begin
                tail[j] = entry.size_ext ? fome_pkg::SIZE_EXT_BYTE
                                         : (fome_pkg::STOP_MARK
                                            | {1'b0, entry.order_size[6:0]});
            end
            else if (j == 1 && entry.size_ext)
            begin
                tail[j] = fome_pkg::STOP_MARK | {1'b0, entry.order_size[6:0]};
            end
            else if (rel <= ngrp_w)
            begin
                tail[j] = grp[idx[2:0]];
            end
            else if (rel == ngrp_w + 5'd1)
            begin
                tail[j] = fome_pkg::STOP_MARK | {5'b0, entry.order_type};
            end
        end
    end

    // Whole message, byte k in bits 8k+7 down to 8k.
    always_comb
    begin
        msg[7:0]   = fome_pkg::PMAP_BYTE;
        msg[15:8]  = fome_pkg::TEMPLATE_BYTE;
        msg[23:16] = fome_pkg::EXP_BYTE;
        msg[31:24] = fome_pkg::PRICE_BYTE;
        for (int j = 0; j < fome_pkg::TAIL_BYTES; j++)
        begin
            msg[(fome_pkg::HEAD_BYTES + j)*8 +: 8] = tail[j];
        end
    end

    // A new beat loads when the output register is free or being taken.
    assign load      = entry_valid && (!out_valid_reg || pop);
    assign entry_pop = load && half_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        half_next      = half_reg;
        if (out_valid_reg && pop)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
            half_next      = !half_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            half_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            half_reg      <= half_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg  <= half_reg ? msg[127:64] : msg[63:0];
            last_reg  <= half_reg;
            count_reg <= half_reg ? fome_pkg::COUNT_LAST : fome_pkg::COUNT_FIRST;
            tag_reg   <= entry.time_tag;
        end
    end

    assign empty      = !out_valid_reg;
    assign data_word  = data_reg;
    assign last_word  = last_reg;
    assign byte_count = count_reg;
    assign tag_out    = tag_reg;

endmodule

FILE: rtl/fast_order_message_encoder_core.sv
// Channel   Handshake          Beat contents
// order     push / full        order_size, order_id, order_type, time_tag
// message   pop / empty        data_word, last_word, byte_count, tag_out
//
// Each order yields two message beats, sent through the single 64-bit output
// register. A taken order passes through the front register and the queue
// before the output register loads its first beat.
// Reset clears the front stage, the queue and the output register; no data is lost
// or repeated while either side stalls, and the queue lets the front keep taking
// orders while the back waits on pop.
module fast_order_message_encoder_core
#(
    parameter int QUEUE_DEPTH = fome_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [fome_pkg::SIZE_W-1:0]     order_size,
    input  logic [fome_pkg::ID_W-1:0]       order_id,
    input  logic [fome_pkg::TYPE_W-1:0]     order_type,
    input  logic [fome_pkg::TAG_W-1:0]      time_tag,
    output logic                            empty,
    input  logic                            pop,
    output logic [fome_pkg::WORD_W-1:0]     data_word,
    output logic                            last_word,
    output logic [fome_pkg::COUNT_W-1:0]    byte_count,
    output logic [fome_pkg::TAG_W-1:0]      tag_out
);

    logic                   front_valid;
    logic                   front_ready;
    fome_pkg::order_entry_t front_entry;
    logic                   head_valid;
    logic                   head_pop;
    fome_pkg::order_entry_t head_entry;

    // Front: takes orders and classifies the message layout.
    fome_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .order_size  (order_size),
        .order_id    (order_id),
        .order_type  (order_type),
        .time_tag    (time_tag),
        .entry_valid (front_valid),
        .entry       (front_entry),
        .entry_ready (front_ready)
    );

    // Queue between front and back.
    fome_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_entry (front_entry),
        .rd_valid (head_valid),
        .rd_pop   (head_pop),
        .rd_entry (head_entry)
    );

    // Back: builds the message and sends it as two beats.
    fome_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry_valid (head_valid),
        .entry       (head_entry),
        .entry_pop   (head_pop),
        .empty       (empty),
        .pop         (pop),
        .data_word   (data_word),
        .last_word   (last_word),
        .byte_count  (byte_count),
        .tag_out     (tag_out)
    );

endmodule
